@@ hdl/assert_macros.svh @@
// assertion macros used by the alu top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ hdl/alu_pkg.sv @@
// shared types and constants of the 8-bit alu with flags
`default_nettype none

package alu_pkg;

   // operation codes
   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,
      OP_ADC  = 5'd1,
      OP_SUB  = 5'd2,
      OP_SBC  = 5'd3,
      OP_AND  = 5'd4,
      OP_XOR  = 5'd5,
      OP_OR   = 5'd6,
      OP_CP   = 5'd7,
      OP_INC  = 5'd8,
      OP_DEC  = 5'd9,
      OP_DAA  = 5'd10,
      OP_CPL  = 5'd11,
      OP_SCF  = 5'd12,
      OP_CCF  = 5'd13,
      OP_RLC  = 5'd14,
      OP_RRC  = 5'd15,
      OP_RL   = 5'd16,
      OP_RR   = 5'd17,
      OP_SLA  = 5'd18,
      OP_SRA  = 5'd19,
      OP_SWAP = 5'd20,
      OP_SRL  = 5'd21,
      OP_BIT  = 5'd22,
      OP_RES  = 5'd23,
      OP_SET  = 5'd24,
      OP_RLCA = 5'd25,
      OP_RRCA = 5'd26,
      OP_RLA  = 5'd27,
      OP_RRA  = 5'd28
   } alu_op_type;

   // flag bit positions
   localparam int FlagZ = 3;
   localparam int FlagN = 2;
   localparam int FlagH = 1;
   localparam int FlagC = 0;

   // decimal adjust limits and corrections
   localparam logic [3:0] DaaLowLimit  = 4'd9;
   localparam logic [7:0] DaaHighLimit = 8'd153;
   localparam logic [7:0] DaaLowCorr   = 8'h06;
   localparam logic [7:0] DaaHighCorr  = 8'h60;

   // one registered operation request
   typedef struct packed {
      alu_op_type op;
      logic [7:0] operand_a;
      logic [7:0] operand_b;
      logic [2:0] bit_index;
      logic [3:0] flags_in;
   } alu_req_type;

   // one computed response
   typedef struct packed {
      logic [7:0] result;
      logic [3:0] flags_out;
      logic       write_result;
   } alu_rsp_type;

endpackage

`default_nettype wire

@@ hdl/alu_core.sv @@
// combinational datapath: adder, logic ops, decimal adjust, shifter and bit ops
`default_nettype none

module alu_core
   import alu_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [7:0] a;
   logic [7:0] b;
   logic       cin;
   logic       hin;
   logic       nin;
   logic       zin;
   logic       carry_in;
   logic [8:0] sum9;
   logic [8:0] diff9;
   logic [4:0] hsum5;
   logic [4:0] hdiff5;
   logic [7:0] daa_corr;
   logic       daa_carry;
   logic [7:0] daa_res;
   logic [7:0] rot_res;
   logic       rot_carry;
   logic [7:0] bit_mask;

   assign a   = req.operand_a;
   assign b   = req.operand_b;
   assign cin = req.flags_in[FlagC];
   assign hin = req.flags_in[FlagH];
   assign nin = req.flags_in[FlagN];
   assign zin = req.flags_in[FlagZ];

   // carry into the adder only for the with-carry forms
   assign carry_in = ((req.op == OP_ADC) || (req.op == OP_SBC)) ? cin : 1'b0;

   // shared add and subtract with nibble carries
   assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, carry_in};
   assign diff9  = {1'b0, a} - {1'b0, b} - {8'd0, carry_in};
   assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_in};
   assign hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, carry_in};

   // decimal adjust correction
   always_comb begin
      daa_corr  = 8'd0;
      daa_carry = 1'b0;
      if (hin || (!nin && (a[3:0] > DaaLowLimit))) begin
         daa_corr = DaaLowCorr;
      end
      if (cin || (!nin && (a > DaaHighLimit))) begin
         daa_corr  = daa_corr | DaaHighCorr;
         daa_carry = 1'b1;
      end
      daa_res = nin ? (a - daa_corr) : (a + daa_corr);
   end

   // rotates, shifts and swap, accumulator forms included
   always_comb begin
      rot_res   = a;
      rot_carry = 1'b0;
      unique case (req.op)
         OP_RLC, OP_RLCA: begin
            rot_carry = a[7];
            rot_res   = {a[6:0], a[7]};
         end
         OP_RRC, OP_RRCA: begin
            rot_carry = a[0];
            rot_res   = {a[0], a[7:1]};
         end
         OP_RL, OP_RLA: begin
            rot_carry = a[7];
            rot_res   = {a[6:0], cin};
         end
         OP_RR, OP_RRA: begin
            rot_carry = a[0];
            rot_res   = {cin, a[7:1]};
         end
         OP_SLA: begin
            rot_carry = a[7];
            rot_res   = {a[6:0], 1'b0};
         end
         OP_SRA: begin
            rot_carry = a[0];
            rot_res   = {a[7], a[7:1]};
         end
         OP_SWAP: begin
            rot_carry = 1'b0;
            rot_res   = {a[3:0], a[7:4]};
         end
         OP_SRL: begin
            rot_carry = a[0];
            rot_res   = {1'b0, a[7:1]};
         end
         default: begin
            rot_carry = 1'b0;
            rot_res   = a;
         end
      endcase
   end

   assign bit_mask = 8'd1 << req.bit_index;

   // result and flag select
   always_comb begin
      rsp.result       = a;
      rsp.flags_out    = req.flags_in;
      rsp.write_result = 1'b1;
      unique case (req.op)
         OP_ADD, OP_ADC: begin
            rsp.result    = sum9[7:0];
            rsp.flags_out = {(sum9[7:0] == 8'd0), 1'b0, hsum5[4], sum9[8]};
         end
         OP_SUB, OP_SBC, OP_CP: begin
            rsp.result       = diff9[7:0];
            rsp.flags_out    = {(diff9[7:0] == 8'd0), 1'b1, hdiff5[4], diff9[8]};
            rsp.write_result = (req.op != OP_CP);
         end
         OP_AND: begin
            rsp.result    = a & b;
            rsp.flags_out = {((a & b) == 8'd0), 1'b0, 1'b1, 1'b0};
         end
         OP_XOR: begin
            rsp.result    = a ^ b;
            rsp.flags_out = {((a ^ b) == 8'd0), 1'b0, 1'b0, 1'b0};
         end
         OP_OR: begin
            rsp.result    = a | b;
            rsp.flags_out = {((a | b) == 8'd0), 1'b0, 1'b0, 1'b0};
         end
         OP_INC: begin
            rsp.result    = a + 8'd1;
            rsp.flags_out = {(a == 8'hff), 1'b0, (a[3:0] == 4'hf), cin};
         end
         OP_DEC: begin
            rsp.result    = a - 8'd1;
            rsp.flags_out = {(a == 8'h01), 1'b1, (a[3:0] == 4'h0), cin};
         end
         OP_DAA: begin
            rsp.result    = daa_res;
            rsp.flags_out = {(daa_res == 8'd0), nin, 1'b0, daa_carry};
         end
         OP_CPL: begin
            rsp.result    = ~a;
            rsp.flags_out = {zin, 1'b1, 1'b1, cin};
         end
         OP_SCF: begin
            rsp.flags_out = {zin, 1'b0, 1'b0, 1'b1};
         end
         OP_CCF: begin
            rsp.flags_out = {zin, 1'b0, 1'b0, !cin};
         end
         OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
            rsp.result    = rot_res;
            rsp.flags_out = {(rot_res == 8'd0), 1'b0, 1'b0, rot_carry};
         end
         OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
            // accumulator rotates always clear zero
            rsp.result    = rot_res;
            rsp.flags_out = {1'b0, 1'b0, 1'b0, rot_carry};
         end
         OP_BIT: begin
            rsp.flags_out    = {!a[req.bit_index], 1'b0, 1'b1, cin};
            rsp.write_result = 1'b0;
         end
         OP_RES: begin
            rsp.result = a & ~bit_mask;
         end
         OP_SET: begin
            rsp.result = a | bit_mask;
         end
         default: begin
            // unused codes pass the operand and flags, no write-back
            rsp.write_result = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/cpu_alu_with_flags.sv @@
// Top level of the 8-bit alu with Z/N/H/C flags. A transaction is taken at every
// clock edge where start is high and busy is low; busy is always low, so one
// transaction can enter in every cycle. Each transaction goes through an input
// register and the combinational datapath into a result register. Its result is
// on the rsp_ ports from the clock edge after the one that took it, for
// exactly one cycle marked by rsp_valid. The receiver cannot stall: a result is
// gone after that cycle. Results come out in the order the transactions were taken.
`default_nettype none
`include "assert_macros.svh"

module cpu_alu_with_flags
   import alu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [4:0] req_type,
   input  logic [7:0] req_operand_a,
   input  logic [7:0] req_operand_b,
   input  logic [2:0] req_bit_index,
   input  logic [3:0] req_flags_in,
   output logic       rsp_valid,
   output logic [7:0] rsp_result,
   output logic [3:0] rsp_flags_out,
   output logic       rsp_write_result
);

   logic        req_valid_ff;
   logic        req_valid_in;
   alu_req_type req_ff;
   alu_req_type req_in;
   alu_rsp_type core_rsp;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   alu_rsp_type rsp_ff;

   // the datapath takes a transaction in every cycle
   assign busy = 1'b0;

   // input register
   assign req_valid_in = start && !busy;
   assign req_in = '{op:        alu_op_type'(req_type),
                     operand_a: req_operand_a,
                     operand_b: req_operand_b,
                     bit_index: req_bit_index,
                     flags_in:  req_flags_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_in;
      end
   end

   // combinational datapath
   alu_core u_core (
      .req (req_ff),
      .rsp (core_rsp)
   );

   // result register
   assign rsp_valid_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result       = rsp_ff.result;
   assign rsp_flags_out    = rsp_ff.flags_out;
   assign rsp_write_result = rsp_ff.write_result;

   // an accepted transaction loads the input stage
   `ASSERT_CLK(a_accept_loads, clock, reset, (start && !busy) |=> req_valid_ff, "accepted transaction not registered")
   // a loaded input stage yields a result strobe next cycle
   `ASSERT_CLK(a_stage_to_rsp, clock, reset, req_valid_ff |=> rsp_valid, "input stage did not reach the result register")
   // no result strobe without a transaction taken through the input and result registers
   `ASSERT_CLK(a_no_invented, clock, reset, rsp_valid |-> $past(start && !busy, 2), "result strobe without a transaction")
   // compare and bit test never request write-back
   `ASSERT_NEVER(a_no_cp_write, clock, reset, rsp_valid_in && ((req_ff.op == OP_CP) || (req_ff.op == OP_BIT)) && core_rsp.write_result, "write-back on compare or bit test")

endmodule

`default_nettype wire
